// File: hdl/rtc3w_pkg.sv
`timescale 1ns / 1ps

package rtc3w_pkg;

    // Final bit phase: high half of bit 15
    localparam logic [5:0] LAST_PHASE = 6'd32;

    // First bit index that is sampled on a read transfer
    localparam logic [4:0] FIRST_READ_BIT = 5'd8;

    // Register indexes on the configuration port
    localparam logic REG_HALF_PERIOD = 1'b0;

    // Reset value of the half-period register
    localparam logic [7:0] HALF_PERIOD_RESET = 8'd1;

    // One tick of input, as unpacked from the slave-side beat
    typedef struct packed {
        logic       data_pin_in;
        logic [7:0] write_data;
        logic [7:0] command_byte;
        logic       start_req;
    } tick_t;

    // One result beat; packed order puts enable_pin in bit 0
    typedef struct packed {
        logic [6:0] read_decoded;
        logic [7:0] read_raw;
        logic       done_res;
        logic       busy_res;
        logic       data_pin_drive;
        logic       data_pin_out;
        logic       clock_pin;
        logic       enable_pin;
    } result_t;

    // Read the hex form of a byte as decimal digits, stopping at the first
    // digit above nine
    function automatic logic [6:0] decode_hex_as_decimal(input logic [7:0] v);
        logic [3:0] hi;
        logic [3:0] lo;
        logic [6:0] res;
        hi = v[7:4];
        lo = v[3:0];
        if (hi == 4'd0)
        begin
            res = (lo <= 4'd9) ? {3'b000, lo} : 7'd0;
        end
        else if (hi > 4'd9)
        begin
            res = 7'd0;
        end
        else if (lo > 4'd9)
        begin
            res = {3'b000, hi};
        end
        else
        begin
            res = 7'({3'b000, hi} * 7'd10 + {3'b000, lo});
        end
        return res;
    endfunction

endpackage

// File: hdl/rtc3w_core.sv
`timescale 1ns / 1ps

module rtc3w_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  rtc3w_pkg::tick_t    tick,
    input  logic [7:0]          half_period,
    output rtc3w_pkg::result_t  result
);

    logic [7:0]  tick_count_reg;
    logic [7:0]  tick_count_next;
    logic [5:0]  phase_count_reg;
    logic [5:0]  phase_count_next;
    logic [15:0] shift_out_reg;
    logic [15:0] shift_out_next;
    logic [7:0]  shift_in_reg;
    logic [7:0]  shift_in_next;
    logic        is_read_reg;
    logic        is_read_next;
    logic        active_reg;
    logic        active_next;
    logic [7:0]  last_read_reg;
    logic [7:0]  last_read_next;

    logic        start_now;
    logic        act;
    logic        isr;
    logic [15:0] so;
    logic [7:0]  si;
    logic [5:0]  ph;
    logic [7:0]  tc;
    logic [7:0]  h;
    logic        last;
    logic [5:0]  ph_m1;
    logic        high;
    logic        reading;
    logic        en;
    logic        clk_lvl;
    logic        dout;
    logic        drv;
    logic        done;

    // Work out one tick: latch a start, then step the current phase
    always_comb
    begin
        start_now = !active_reg && tick.start_req;
        act       = active_reg || start_now;
        isr       = start_now ? tick.command_byte[0] : is_read_reg;
        so        = start_now ? {tick.write_data, tick.command_byte} : shift_out_reg;
        si        = start_now ? 8'd0 : shift_in_reg;
        ph        = start_now ? 6'd0 : phase_count_reg;
        tc        = start_now ? 8'd0 : tick_count_reg;

        h         = (half_period == 8'd0) ? 8'd1 : half_period;
        last      = ({1'b0, tc} + 9'd1) >= {1'b0, h};
        ph_m1     = ph - 6'd1;
        high      = ph_m1[0];
        reading   = isr && (ph_m1[5:1] >= rtc3w_pkg::FIRST_READ_BIT);

        en        = 1'b0;
        clk_lvl   = 1'b0;
        dout      = 1'b0;
        drv       = 1'b0;
        done      = 1'b0;

        is_read_next     = isr;
        shift_out_next   = so;
        shift_in_next    = si;
        phase_count_next = ph;
        tick_count_next  = tc;
        active_next      = act;
        last_read_next   = last_read_reg;

        if (act)
        begin
            // Drive the lines inside the bit phases
            if (ph != 6'd0)
            begin
                en      = 1'b1;
                clk_lvl = high;
                if (!reading)
                begin
                    drv  = 1'b1;
                    dout = so[0];
                end
                if (reading && !high && last)
                begin
                    shift_in_next = {tick.data_pin_in, si[7:1]};
                end
                if (high && last)
                begin
                    shift_out_next = {1'b0, so[15:1]};
                end
            end

            // Advance the tick and phase counters
            if (last)
            begin
                tick_count_next = 8'd0;
                if (ph >= rtc3w_pkg::LAST_PHASE)
                begin
                    done             = 1'b1;
                    active_next      = 1'b0;
                    phase_count_next = 6'd0;
                    if (isr)
                    begin
                        last_read_next = si;
                    end
                end
                else
                begin
                    phase_count_next = ph + 6'd1;
                end
            end
            else
            begin
                tick_count_next = tc + 8'd1;
            end
        end

        result.enable_pin     = en;
        result.clock_pin      = clk_lvl;
        result.data_pin_out   = dout;
        result.data_pin_drive = drv;
        result.busy_res       = act;
        result.done_res       = done;
        result.read_raw       = last_read_next;
        result.read_decoded   = rtc3w_pkg::decode_hex_as_decimal(last_read_next);
    end

    // Hold state between ticks; advance on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg  <= 8'd0;
            phase_count_reg <= 6'd0;
            shift_out_reg   <= 16'd0;
            shift_in_reg    <= 8'd0;
            is_read_reg     <= 1'b0;
            active_reg      <= 1'b0;
            last_read_reg   <= 8'd0;
        end
        else if (advance)
        begin
            tick_count_reg  <= tick_count_next;
            phase_count_reg <= phase_count_next;
            shift_out_reg   <= shift_out_next;
            shift_in_reg    <= shift_in_next;
            is_read_reg     <= is_read_next;
            active_reg      <= active_next;
            last_read_reg   <= last_read_next;
        end
    end

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_count_reg <= rtc3w_pkg::LAST_PHASE)
        else $error("phase count past last phase");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result.done_res) |=> !active_reg)
        else $error("transfer still active after done");

    a_enable_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result.enable_pin || result.done_res) |-> result.busy_res)
        else $error("enable or done outside a transfer");

    a_release_low: assert property (@(posedge clk) disable iff (!rst_n)
        !result.data_pin_drive |-> !result.data_pin_out)
        else $error("data driven high while released");
`endif

endmodule

// File: hdl/rtc3w_out_stage.sv
`timescale 1ns / 1ps

module rtc3w_out_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  rtc3w_pkg::result_t  result,
    input  logic                take,
    output logic                room,
    output logic                valid,
    output rtc3w_pkg::result_t  data
);

    logic               valid_reg;
    logic               valid_next;
    rtc3w_pkg::result_t data_reg;

    // Accept a new result when empty or when the held one leaves this cycle
    assign room = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold the flag under reset; the payload needs none
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// File: hdl/three_wire_rtc_serial_master_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Signals                                   Beat
// s_axis    in   s_tvalid s_tready s_tdata[23:0]            one time tick
// m_axis    out  m_tvalid m_tready m_tdata[23:0]            one result per tick
// apb       in   psel penable pwrite paddr pwdata prdata    half_period_ticks
//
// Each tick beat's result lands in the output register on the same edge that
// takes the beat, so one beat per cycle flows while m_tready holds.
// The output register stalls the input side only while its result waits.
// rst_n clears the transfer state, the held result flag and sets the half
// period to one tick.

module three_wire_rtc_serial_master_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] start_req, [8:1] command_byte, [16:9] write_data, [17] data_pin_in,
    // [23:18] zero
    input  logic [23:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] enable_pin, [1] clock_pin, [2] data_pin_out, [3] data_pin_drive,
    // [4] busy_res, [5] done_res, [13:6] read_raw, [20:14] read_decoded,
    // [23:21] zero
    output logic [23:0] m_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic               half_period_sel;
    logic [7:0]         half_period_q_reg;
    logic               cfg_write;
    logic               accept;
    logic               take;
    rtc3w_pkg::tick_t   tick;
    rtc3w_pkg::result_t result;
    rtc3w_pkg::result_t out_data;

    // Configuration register write and read-back
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign half_period_sel = (paddr[2] == rtc3w_pkg::REG_HALF_PERIOD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_q_reg <= rtc3w_pkg::HALF_PERIOD_RESET;
        end
        else if (cfg_write && half_period_sel)
        begin
            half_period_q_reg <= pwdata[7:0];
        end
    end

    assign prdata = half_period_sel ? {24'd0, half_period_q_reg} : 32'd0;

    // Unpack the tick beat and step the master
    assign tick   = rtc3w_pkg::tick_t'(s_tdata[17:0]);
    assign accept = s_tvalid && s_tready;
    assign take   = m_tvalid && m_tready;

    rtc3w_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (accept),
        .tick        (tick),
        .half_period (half_period_q_reg),
        .result      (result)
    );

    rtc3w_out_stage u_out
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .result (result),
        .take   (take),
        .room   (s_tready),
        .valid  (m_tvalid),
        .data   (out_data)
    );

    assign m_tdata = {3'b000, out_data};

endmodule
